@@ src/frc_pkg.sv @@
// Shared constants and field widths for the frame chunk reassembler.
// No dependencies; the interfaces and the core import this package.
package frc_pkg;

	// Default store capacity and chunk payload size.
	localparam int FRC_MAX_FRAME_BYTES = 65536;
	localparam int FRC_CHUNK_BYTES     = 25;

	// Field widths of the item, result and configuration beats.
	localparam int OPCODE_W   = 1;
	localparam int TAG_W      = 16;
	localparam int CHUNK_W    = 16;
	localparam int POS_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int RADDR_W    = 16;
	localparam int DIM_W      = 11;
	localparam int REG_IDX_W  = 1;

	// Width x height product, and the frame size in bytes (three per pixel).
	localparam int PROD_W  = 2 * DIM_W;
	localparam int BYTES_W = PROD_W + 2;

	// Item operation codes.
	localparam logic [OPCODE_W-1:0] OP_DELIVER = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_READ    = 1'b1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Reset value of both frame dimensions.
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1;

endpackage

@@ src/frc_if.sv @@
// Valid/ready channel interfaces for the frame chunk reassembler.
// Depends on frc_pkg for field widths.
interface frc_item_if import frc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TAG_W-1:0]    frame_tag;
	logic [CHUNK_W-1:0]  chunk_index;
	logic [POS_W-1:0]    byte_position;
	logic [BYTE_W-1:0]   payload_byte;
	logic [RADDR_W-1:0]  read_address;

	modport source (output valid, opcode, frame_tag, chunk_index, byte_position,
		payload_byte, read_address, input ready);
	modport sink (input valid, opcode, frame_tag, chunk_index, byte_position,
		payload_byte, read_address, output ready);
endinterface

interface frc_result_if import frc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              frame_ready;
	logic              byte_dropped;
	logic [TAG_W-1:0]  current_frame;

	modport source (output valid, read_byte, frame_ready, byte_dropped, current_frame,
		input ready);
	modport sink (input valid, read_byte, frame_ready, byte_dropped, current_frame,
		output ready);
endinterface

interface frc_cfg_if import frc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [DIM_W-1:0]     write_data;

	modport source (output valid, reg_index, write_data, input ready);
	modport sink (input valid, reg_index, write_data, output ready);
endinterface

@@ src/frame_chunk_reassembler_core.sv @@
// Frame chunk reassembler: frame byte store, chunk received marks and sequencer.
// Depends on frc_pkg and the channel interfaces in frc_if.sv.
//
// Usage: the item channel carries one beat per payload byte (deliver) or per
// frame byte lookup (read); every item produces exactly one result beat, in
// order. The cfg channel writes frame_width (index 0) and frame_height
// (index 1); it is always ready and must only be used while the block is idle.
//
// Sequencing: an item is accepted in the idle state; ST_CALC computes the
// width x height product and the store address, ST_LOOK accesses the store and
// the received-mark memory, and ST_DONE updates the mark count and loads the
// output register. A new item is accepted only after the previous one has
// loaded its result. A delivered byte with a new frame tag first runs a
// clearing pass over all MAX_FRAME_BYTES store addresses (65536 by default)
// in ST_WIPE before ST_LOOK.
//
// Reset: the same clearing pass runs after reset; no item is accepted until it
// finishes, while configuration writes are taken at once. Stalls: the next item
// is accepted while a result waits in the output register; its own result is
// held until the register frees.
module frame_chunk_reassembler_core
	import frc_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = FRC_MAX_FRAME_BYTES,
	parameter int CHUNK_BYTES     = FRC_CHUNK_BYTES
) (
	input logic           clk,
	input logic           arst_n,
	frc_item_if.sink      item,
	frc_result_if.source  result,
	frc_cfg_if.sink       cfg
);

	// Derived sizes.
	localparam int SEEN_DEPTH  = (MAX_FRAME_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
	localparam int AW          = $clog2(MAX_FRAME_BYTES);
	localparam int SW          = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam int CW          = $clog2(SEEN_DEPTH + 1);
	localparam int CHB_W       = $clog2(CHUNK_BYTES + 1);
	localparam int ADDR_CALC_W = CHUNK_W + CHB_W + 1;
	localparam int PRODC_W     = CW + CHB_W;
	localparam int CMP_A       = (ADDR_CALC_W > BYTES_W) ? ADDR_CALC_W : BYTES_W;
	localparam int CMP_B       = (CMP_A > AW + 1) ? CMP_A : AW + 1;
	localparam int CMP_W       = (CMP_B > PRODC_W) ? CMP_B : PRODC_W;

	// Sequencer states.
	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_WIPE = 3'd3;
	localparam logic [2:0] ST_LOOK = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]          state_q;
	logic [AW-1:0]       sweep_q;
	logic [TAG_W-1:0]    frame_q;
	logic [CW-1:0]       count_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;

	// The item being worked on.
	logic [OPCODE_W-1:0] op_q;
	logic [TAG_W-1:0]    tag_q;
	logic [CHUNK_W-1:0]  chunk_q;
	logic [POS_W-1:0]    pos_q;
	logic [BYTE_W-1:0]   val_q;
	logic [RADDR_W-1:0]  raddr_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ADDR_CALC_W-1:0] addr_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic                drop_q;
	logic                mark_q;
	logic                rd_ok_q;

	// Output register.
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_ready_q;
	logic                out_drop_q;
	logic [TAG_W-1:0]    out_frame_q;

	// Memories and their ports.
	logic [BYTE_W-1:0]   store_mem [MAX_FRAME_BYTES];
	logic                seen_mem  [SEEN_DEPTH];
	logic                store_we;
	logic [AW-1:0]       store_addr;
	logic [BYTE_W-1:0]   store_wdata;
	logic [BYTE_W-1:0]   store_rd_q;
	logic                seen_we;
	logic [SW-1:0]       seen_addr;
	logic                seen_wdata;
	logic                seen_rd_q;

	// Combinational helpers.
	logic                sweeping;
	logic                sweep_last;
	logic [BYTES_W-1:0]  bytes_c;
	logic [CMP_W-1:0]    addr_x;
	logic [CMP_W-1:0]    bytes_x;
	logic [CMP_W-1:0]    max_x;
	logic [CMP_W-1:0]    raddr_x;
	logic [CMP_W-1:0]    pos_x;
	logic [CMP_W-1:0]    chunk_x;
	logic [CMP_W-1:0]    sweep_x;
	logic                drop_c;
	logic                last_c;
	logic                rd_ok_c;
	logic                out_free;
	logic                mark_now;
	logic [CW-1:0]       count_next;
	logic                frame_ready_c;

	assign sweeping   = (state_q == ST_INIT) || (state_q == ST_WIPE);
	assign sweep_last = (sweep_q == AW'(MAX_FRAME_BYTES - 1));
	assign out_free   = !out_valid_q || result.ready;

	// Frame size is taken from the registered width x height product.
	assign bytes_c = BYTES_W'({prod_q, 1'b0}) + BYTES_W'(prod_q);

	assign addr_x  = CMP_W'(addr_q);
	assign bytes_x = CMP_W'(bytes_c);
	assign max_x   = CMP_W'(MAX_FRAME_BYTES);
	assign raddr_x = CMP_W'(raddr_q);
	assign pos_x   = CMP_W'(pos_q);
	assign chunk_x = CMP_W'(chunk_q);
	assign sweep_x = CMP_W'(sweep_q);

	// A byte is dropped when its position lies outside the chunk, or its
	// address lies past the frame end or the store end.
	assign drop_c  = (pos_x >= CMP_W'(CHUNK_BYTES)) || (addr_x >= bytes_x) ||
		(addr_x >= max_x);
	// The last position of a chunk or the last byte of the frame closes a chunk.
	assign last_c  = (pos_x == CMP_W'(CHUNK_BYTES - 1)) ||
		(addr_x + CMP_W'(1) == bytes_x);
	assign rd_ok_c = (raddr_x < bytes_x) && (raddr_x < max_x);

	// A chunk that is closed and not yet marked adds one to the count. The
	// frame is ready when count * CHUNK_BYTES covers the frame size, which is
	// the same as count >= ceil(bytes / CHUNK_BYTES).
	assign mark_now      = mark_q && !seen_rd_q;
	assign count_next    = count_q + CW'(mark_now);
	assign frame_ready_c = (CMP_W'(count_next) * CMP_W'(CHUNK_BYTES)) >= CMP_W'(bytes_q);

	// Memory port selection. The clearing pass owns both memories; otherwise
	// the store is addressed by the item and the marks by its chunk number.
	always_comb begin
		store_we    = 1'b0;
		store_wdata = '0;
		seen_we     = 1'b0;
		seen_wdata  = 1'b0;
		if (sweeping) begin
			store_addr = sweep_q;
			seen_addr  = sweep_q[SW-1:0];
		end else begin
			store_addr = (op_q == OP_READ) ? raddr_x[AW-1:0] : addr_x[AW-1:0];
			seen_addr  = chunk_x[SW-1:0];
		end
		case (state_q)
			ST_INIT, ST_WIPE: begin
				store_we = 1'b1;
				seen_we  = (sweep_x < CMP_W'(SEEN_DEPTH));
			end
			ST_LOOK: begin
				store_we    = (op_q == OP_DELIVER) && !drop_c;
				store_wdata = val_q;
			end
			ST_DONE: begin
				seen_we    = out_free && mark_now;
				seen_wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Byte store: single port, read data registered, read before write.
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_addr] <= store_wdata;
		end
		store_rd_q <= store_mem[store_addr];
	end

	// Chunk received marks: single port, read data registered.
	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_addr] <= seen_wdata;
		end
		seen_rd_q <= seen_mem[seen_addr];
	end

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg.write_data;
				REG_FRAME_HEIGHT: height_q <= cfg.write_data;
				default: begin
				end
			endcase
		end
	end

	// Item payload registers; no reset needed.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q    <= item.opcode;
			tag_q   <= item.frame_tag;
			chunk_q <= item.chunk_index;
			pos_q   <= item.byte_position;
			val_q   <= item.payload_byte;
			raddr_q <= item.read_address;
		end
		if (state_q == ST_CALC) begin
			prod_q <= PROD_W'(width_q) * PROD_W'(height_q);
			addr_q <= ADDR_CALC_W'(chunk_q) * ADDR_CALC_W'(CHUNK_BYTES) +
				ADDR_CALC_W'(pos_q);
		end
		if (state_q == ST_LOOK) begin
			bytes_q <= bytes_c;
			drop_q  <= drop_c;
			mark_q  <= (op_q == OP_DELIVER) && !drop_c && last_c;
			rd_ok_q <= rd_ok_c;
		end
	end

	assign item.ready = (state_q == ST_IDLE);

	// Sequencer, frame tag, mark count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			frame_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_ready_q <= 1'b0;
			out_drop_q  <= 1'b0;
			out_frame_q <= '0;
		end else begin
			// A taken beat empties the output register unless a new one loads.
			if (result.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					// A delivery for another frame restarts assembly from an
					// empty store.
					if ((op_q == OP_DELIVER) && (tag_q != frame_q)) begin
						frame_q <= tag_q;
						count_q <= '0;
						sweep_q <= '0;
						state_q <= ST_WIPE;
					end else begin
						state_q <= ST_LOOK;
					end
				end
				ST_WIPE: begin
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= ST_LOOK;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_LOOK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						count_q     <= count_next;
						out_valid_q <= 1'b1;
						out_byte_q  <= ((op_q == OP_READ) && rd_ok_q) ? store_rd_q : '0;
						out_ready_q <= frame_ready_c;
						out_drop_q  <= (op_q == OP_DELIVER) && drop_q;
						out_frame_q <= frame_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.read_byte     = out_byte_q;
	assign result.frame_ready   = out_ready_q;
	assign result.byte_dropped  = out_drop_q;
	assign result.current_frame = out_frame_q;

endmodule

@@ bench/frame_chunk_reassembler_core_tb.sv @@
// Self-checking bench for frame_chunk_reassembler_core: directed and random items,
// a frame mirror class that predicts every result beat, and random idling on both sides.
// Depends on frc_pkg and the channel interfaces in src/frc_if.sv.
`timescale 1ns / 1ps

module frame_chunk_reassembler_core_tb
	import frc_pkg::*;
();

	// Depth of the received-mark table: one mark per chunk of the store.
	localparam int MARK_DEPTH = (FRC_MAX_FRAME_BYTES + FRC_CHUNK_BYTES - 1) / FRC_CHUNK_BYTES;

	// Slowest correct run: six store clears after reset and tag changes plus about
	// 1200 items, stretched by sender gaps, receiver stalls and one long hold-off.
	// The limit is set well above that.
	localparam longint CYCLE_LIMIT = 4_000_000;

	// Length of the long receiver hold-off that fills the block and stalls its input.
	localparam int LONG_HOLD = 400;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [TAG_W-1:0]    frame_tag;
		logic [CHUNK_W-1:0]  chunk_index;
		logic [POS_W-1:0]    byte_position;
		logic [BYTE_W-1:0]   payload_byte;
		logic [RADDR_W-1:0]  read_address;
	} frame_item_t;

	typedef struct {
		logic [BYTE_W-1:0] read_byte;
		logic              frame_ready;
		logic              byte_dropped;
		logic [TAG_W-1:0]  current_frame;
	} frame_result_t;

	// Mirror of the reassembly state. Every accepted item is applied here and the
	// result it must produce is queued; result beats are checked in order.
	class frame_mirror_t;
		bit [BYTE_W-1:0] store_bytes [FRC_MAX_FRAME_BYTES];
		bit              chunk_marked [MARK_DEPTH];
		int unsigned     frame_id;
		int unsigned     marks;
		int unsigned     width;
		int unsigned     height;
		int              mismatches;
		frame_result_t   awaited_results [$];

		function new();
			wipe_frame();
			frame_id = 0;
			width = 32'(DIM_RESET);
			height = 32'(DIM_RESET);
			mismatches = 0;
		endfunction

		function void wipe_frame();
			foreach (store_bytes[i])
				store_bytes[i] = '0;
			foreach (chunk_marked[i])
				chunk_marked[i] = 1'b0;
			marks = 0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] index, logic [DIM_W-1:0] data);
			case (index)
				REG_FRAME_WIDTH:  width = 32'(data);
				REG_FRAME_HEIGHT: height = 32'(data);
				default: ;
			endcase
		endfunction

		function void absorb_item(frame_item_t it);
			int unsigned   bytes;
			int unsigned   chunk;
			int unsigned   pos;
			int unsigned   addr;
			int unsigned   need;
			frame_result_t want;
			// The frame size follows the registers as they stand now.
			bytes = width * height * 3;
			want.read_byte = '0;
			want.byte_dropped = 1'b0;
			if (it.opcode == OP_DELIVER) begin
				// A new tag throws away everything gathered for the old frame.
				if (32'(it.frame_tag) != frame_id) begin
					frame_id = 32'(it.frame_tag);
					wipe_frame();
				end
				chunk = 32'(it.chunk_index);
				pos = 32'(it.byte_position);
				addr = chunk * FRC_CHUNK_BYTES + pos;
				if (pos >= FRC_CHUNK_BYTES || addr >= bytes || addr >= FRC_MAX_FRAME_BYTES) begin
					want.byte_dropped = 1'b1;
				end else begin
					store_bytes[addr] = it.payload_byte;
					// A chunk counts once its last slot or the frame's last byte lands.
					if ((pos == FRC_CHUNK_BYTES - 1 || addr == bytes - 1) &&
							chunk < MARK_DEPTH && !chunk_marked[chunk]) begin
						chunk_marked[chunk] = 1'b1;
						marks++;
					end
				end
			end else if (32'(it.read_address) < bytes &&
					32'(it.read_address) < FRC_MAX_FRAME_BYTES) begin
				want.read_byte = store_bytes[it.read_address];
			end
			need = (bytes + FRC_CHUNK_BYTES - 1) / FRC_CHUNK_BYTES;
			want.frame_ready = (marks >= need);
			want.current_frame = TAG_W'(frame_id);
			awaited_results = {awaited_results, want};
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (awaited_results.size() == 0) begin
				$error("result beat arrived with no item waiting for it");
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			if (got.read_byte !== want.read_byte) begin
				$error("read_byte: expected 0x%02h, actual 0x%02h", want.read_byte, got.read_byte);
				mismatches++;
			end
			if (got.frame_ready !== want.frame_ready) begin
				$error("frame_ready: expected %0b, actual %0b", want.frame_ready, got.frame_ready);
				mismatches++;
			end
			if (got.byte_dropped !== want.byte_dropped) begin
				$error("byte_dropped: expected %0b, actual %0b", want.byte_dropped,
					got.byte_dropped);
				mismatches++;
			end
			if (got.current_frame !== want.current_frame) begin
				$error("current_frame: expected 0x%04h, actual 0x%04h", want.current_frame,
					got.current_frame);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	frc_item_if   item_ch ();
	frc_result_if result_ch ();
	frc_cfg_if    cfg_ch ();

	frame_chunk_reassembler_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	frame_mirror_t mirror = new();
	frame_item_t   taken_item;
	frame_result_t taken_result;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            hold_request = 0;
	int            hold_left = 0;
	longint        cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Every beat accepted on the item channel goes into the mirror at the edge that
	// takes it. Signals are read right after the edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
			taken_item.opcode = item_ch.opcode;
			taken_item.frame_tag = item_ch.frame_tag;
			taken_item.chunk_index = item_ch.chunk_index;
			taken_item.byte_position = item_ch.byte_position;
			taken_item.payload_byte = item_ch.payload_byte;
			taken_item.read_address = item_ch.read_address;
			mirror.absorb_item(taken_item);
		end
	end

	// Result beats are checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			taken_result.read_byte = result_ch.read_byte;
			taken_result.frame_ready = result_ch.frame_ready;
			taken_result.byte_dropped = result_ch.byte_dropped;
			taken_result.current_frame = result_ch.current_frame;
			mirror.check_result(taken_result);
		end
	end

	// Register writes are mirrored when the configuration channel takes them.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
			mirror.set_register(cfg_ch.reg_index, cfg_ch.write_data);
	end

	// Receiver side. A hold-off request from the main sequence is counted down here,
	// cycle by cycle; otherwise ready follows the stall rate of the current phase.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Timeout guard: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic void set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 55;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 55;
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct = 32;
			end
		endcase
	endfunction

	function automatic frame_item_t deliver_beat(input logic [TAG_W-1:0] tag,
			input logic [CHUNK_W-1:0] chunk, input logic [POS_W-1:0] pos,
			input logic [BYTE_W-1:0] value);
		frame_item_t it;
		it.opcode = OP_DELIVER;
		it.frame_tag = tag;
		it.chunk_index = chunk;
		it.byte_position = pos;
		it.payload_byte = value;
		it.read_address = RADDR_W'($urandom);
		return it;
	endfunction

	// Reads carry a random tag, chunk and payload: the block must ignore all three.
	function automatic frame_item_t read_beat(input logic [RADDR_W-1:0] addr);
		frame_item_t it;
		it.opcode = OP_READ;
		it.frame_tag = TAG_W'($urandom);
		it.chunk_index = CHUNK_W'($urandom);
		it.byte_position = POS_W'($urandom_range(0, 31));
		it.payload_byte = BYTE_W'($urandom);
		it.read_address = addr;
		return it;
	endfunction

	// Random item for a frame of the given size. Most deliveries land inside the
	// frame so that chunks complete and frame_ready moves; the rest are noise with
	// any chunk and position. Deliveries always keep the phase tag, since a foreign
	// tag would start a full store clear. Reads mostly probe the frame and its edge.
	function automatic frame_item_t random_item(input logic [TAG_W-1:0] tag,
			input int unsigned bytes);
		int unsigned span;
		int unsigned chunks;
		int unsigned pick;
		frame_item_t it;
		span = (bytes < FRC_MAX_FRAME_BYTES) ? bytes : FRC_MAX_FRAME_BYTES;
		chunks = (span + FRC_CHUNK_BYTES - 1) / FRC_CHUNK_BYTES;
		it = read_beat(RADDR_W'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			it.opcode = OP_DELIVER;
			it.frame_tag = tag;
			if (pick < 45) begin
				it.chunk_index = CHUNK_W'($urandom_range(0, chunks));
				if ($urandom_range(0, 3) == 0)
					it.byte_position = POS_W'(FRC_CHUNK_BYTES - 1);
				else
					it.byte_position = POS_W'($urandom_range(0, FRC_CHUNK_BYTES - 1));
			end
		end else if (pick < 85) begin
			it.read_address = RADDR_W'($urandom_range(0,
				(span + 8 < 65536) ? span + 8 : 65535));
		end
		return it;
	endfunction

	// Offers one beat and returns at the edge that accepts it, with valid still high
	// so that a back-to-back beat never drops valid in between.
	task automatic offer_item(input frame_item_t it);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.frame_tag <= it.frame_tag;
		item_ch.chunk_index <= it.chunk_index;
		item_ch.byte_position <= it.byte_position;
		item_ch.payload_byte <= it.payload_byte;
		item_ch.read_address <= it.read_address;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
	endtask

	// Stops offering and waits until every predicted result has been checked, then
	// waits on so that the pipeline is surely empty.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (mirror.outstanding() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes both frame dimensions, width first, in two back-to-back beats.
	task automatic write_dims(input int unsigned w, input int unsigned h);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= REG_FRAME_WIDTH;
		cfg_ch.write_data <= DIM_W'(w);
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.reg_index <= REG_FRAME_HEIGHT;
		cfg_ch.write_data <= DIM_W'(h);
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	// One random phase: drain, reconfigure while idle, then stream random items.
	// A non-negative hold_at starts the long receiver hold-off at that item.
	task automatic run_phase(input int unsigned w, input int unsigned h,
			input logic [TAG_W-1:0] tag, input idle_mode_t mode, input int count,
			input int hold_at);
		drain_results();
		write_dims(w, h);
		set_idling(mode);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = LONG_HOLD;
			offer_item(random_item(tag, w * h * 3));
		end
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_DELIVER;
		item_ch.frame_tag <= '0;
		item_ch.chunk_index <= '0;
		item_ch.byte_position <= '0;
		item_ch.payload_byte <= '0;
		item_ch.read_address <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.reg_index <= REG_FRAME_WIDTH;
		cfg_ch.write_data <= DIM_RESET;
		arst_n <= 1'b0;
		set_idling(IDLE_NONE);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, starting from the reset frame of 1x1 pixels (3 bytes, one
		// chunk) and tag zero. The block sits in its clearing pass first; the
		// first beat simply waits for ready.
		offer_item(read_beat(16'd0));                                 // store clear after reset
		offer_item(deliver_beat(16'h0000, 16'd0, 5'd0, 8'hFF));
		offer_item(deliver_beat(16'h0000, 16'd0, 5'd1, 8'h00));
		offer_item(read_beat(16'd0));
		offer_item(read_beat(16'd2));                                 // not yet written
		offer_item(read_beat(16'd3));                                 // one past frame end
		offer_item(deliver_beat(16'h0000, 16'd0, 5'd2, 8'h81));      // last frame byte marks
		offer_item(deliver_beat(16'h0000, 16'd0, 5'd25, 8'h11));     // position out of chunk
		offer_item(deliver_beat(16'h0000, 16'd0, 5'd31, 8'h22));
		offer_item(deliver_beat(16'h0000, 16'd1, 5'd0, 8'h33));      // past frame end
		offer_item(deliver_beat(16'h0000, 16'hFFFF, 5'd24, 8'h7F));
		offer_item(read_beat(16'hFFFF));
		offer_item(read_beat(16'd2));
		// A new tag wipes the store and the marks before the byte is taken.
		offer_item(deliver_beat(16'hFFFF, 16'd0, 5'd0, 8'hAA));
		offer_item(read_beat(16'd2));
		offer_item(read_beat(16'd0));

		// Largest dimensions: the frame outgrows the store, so the last store byte is
		// kept, the next one is dropped, and the frame can never become ready.
		drain_results();
		write_dims(2047, 2047);
		offer_item(deliver_beat(16'hFFFF, 16'd2621, 5'd10, 8'h55));
		offer_item(deliver_beat(16'hFFFF, 16'd2621, 5'd11, 8'h66));
		offer_item(deliver_beat(16'hFFFF, 16'd0, 5'd24, 8'h01));
		offer_item(read_beat(16'hFFFF));

		// Zero-size frames: everything delivered is dropped and the frame is ready.
		drain_results();
		write_dims(0, 5);
		offer_item(deliver_beat(16'hFFFF, 16'd0, 5'd0, 8'h99));
		offer_item(read_beat(16'd0));
		drain_results();
		write_dims(3, 0);
		offer_item(read_beat(16'd0));

		// Random phases. The first keeps the current tag so that marks set under
		// other dimensions still count; later ones switch tags only at phase start,
		// since each switch costs a full store clear.
		run_phase(5, 5, 16'hFFFF, IDLE_NONE, 220, -1);
		run_phase(7, 3, 16'h5A5A, IDLE_SENDER, 220, -1);
		run_phase(2047, 2047, 16'hA5A5, IDLE_RECEIVER, 200, -1);
		run_phase(0, 9, 16'hA5A5, IDLE_BOTH, 100, -1);
		run_phase(1024, 1024, 16'h1234, IDLE_BOTH, 150, 40);
		run_phase(1, 1, 16'h0F0F, IDLE_BOTH, 200, -1);
		run_phase(1024, 1, 16'h0F0F, IDLE_NONE, 100, -1);

		drain_results();
		repeat (16) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
